/* sv/value_noise_fbm_2d_macros.svh */
// Assertion helpers for the fractal value noise block
`ifndef VALUE_NOISE_FBM_2D_MACROS_SVH
`define VALUE_NOISE_FBM_2D_MACROS_SVH

`define VNF_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

`define VNF_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

/* sv/vnf_pkg.sv */
package vnf_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int OCT_W = 4;
    localparam int HASH_W = 24;
    localparam int ACC_W = 34;
    localparam logic [31:0] UNIT24 = 32'd16777215;
    localparam logic [31:0] OCTAVE_SALT = 32'd101;
    localparam logic [31:0] HASH_KX = 32'd374761393;
    localparam logic [31:0] HASH_KY = 32'd668265263;
    localparam logic [31:0] HASH_KS = 32'd2246822519;
    localparam logic [31:0] HASH_KM = 32'd1274126177;

    localparam int CFG_OCTAVE_COUNT = 0;
    localparam int CFG_NOISE_SEED = 1;

    // floor(2^63 / (UNIT24*(2^k-1))) + 1, product is taken back by 2^48
    localparam logic [63:0] RECIP_NUM = 64'd1 << 63;
    localparam logic [47:0] RECIP_1 = 48'(RECIP_NUM / (64'(UNIT24) * 64'd1) + 64'd1);
    localparam logic [47:0] RECIP_2 = 48'(RECIP_NUM / (64'(UNIT24) * 64'd3) + 64'd1);
    localparam logic [47:0] RECIP_3 = 48'(RECIP_NUM / (64'(UNIT24) * 64'd7) + 64'd1);
    localparam logic [47:0] RECIP_4 = 48'(RECIP_NUM / (64'(UNIT24) * 64'd15) + 64'd1);
    localparam logic [47:0] RECIP_5 = 48'(RECIP_NUM / (64'(UNIT24) * 64'd31) + 64'd1);
    localparam logic [47:0] RECIP_6 = 48'(RECIP_NUM / (64'(UNIT24) * 64'd63) + 64'd1);
    localparam logic [47:0] RECIP_7 = 48'(RECIP_NUM / (64'(UNIT24) * 64'd127) + 64'd1);
    localparam logic [47:0] RECIP_8 = 48'(RECIP_NUM / (64'(UNIT24) * 64'd255) + 64'd1);

    // Q.16 frequency factors of each octave
    function automatic logic [31:0] freq_q16(input int o);
        logic [63:0] f;
        f = 64'd65536;
        for (int i = 0; i < MAX_OCTAVES; i++)
        begin
            if (i < o)
            begin
                f = (f * 64'd132383 + 64'd32768) >> 16;
            end
        end
        return f[31:0];
    endfunction

    function automatic logic [47:0] recip(input int k);
        unique case (k)
            1: return RECIP_1;
            2: return RECIP_2;
            3: return RECIP_3;
            4: return RECIP_4;
            5: return RECIP_5;
            6: return RECIP_6;
            7: return RECIP_7;
            default: return RECIP_8;
        endcase
    endfunction

    // amplitude sum times UNIT24
    function automatic logic [31:0] den_of(input int k);
        return 32'(64'(UNIT24) * ((64'd1 << k) - 64'd1));
    endfunction

    typedef struct packed {
        logic        valid;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] seed;
        logic [OCT_W-1:0] k;
        logic signed [ACC_W-1:0] acc;
    } cell_bus_t;

endpackage

/* sv/vnf_cell.sv */
module vnf_cell
    import vnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [31:0] freq,
    input  logic [OCT_W-1:0] octave,
    input  cell_bus_t   din,
    output cell_bus_t   dout
);
    // stage 1: scaled position
    cell_bus_t s1_reg;
    logic signed [63:0] px_reg, py_reg;
    // stage 2: hash part 1 and fractional positions
    cell_bus_t s2_reg;
    logic [31:0] hp_reg [4];
    logic [15:0] tx_reg, ty_reg;
    // stage 3
    cell_bus_t s3_reg;
    logic [31:0] hm_reg [4];
    logic [32:0] tt_x_reg, tt_y_reg;
    logic [15:0] tx3_reg, ty3_reg;
    // stage 4
    cell_bus_t s4_reg;
    logic [HASH_W-1:0] h_reg [4];
    logic [16:0] sx_reg, sy_reg;
    // stage 5
    cell_bus_t s5_reg;
    logic [HASH_W-1:0] ab_reg, cd_reg;
    logic [16:0] sy5_reg;
    cell_bus_t out_reg;

    logic [31:0] salt;
    logic [31:0] ix, iy;
    logic [31:0] hs [4];
    logic [31:0] hm [4];
    logic [31:0] hx [4];
    logic [HASH_W-1:0] hf [4];
    logic [32:0] sxx, syy;
    logic [HASH_W-1:0] ab, cd, nv;
    logic signed [ACC_W-1:0] vt;
    logic [OCT_W-1:0] shamt;
    logic active;

    always_comb
    begin
        salt = s1_reg.seed + 32'(octave) * OCTAVE_SALT;
        ix = px_reg[63:32];
        iy = py_reg[63:32];
        for (int c = 0; c < 4; c++)
        begin
            hs[c] = (ix + 32'(c & 1)) * HASH_KX + (iy + 32'(c >> 1)) * HASH_KY;
            hm[c] = (hp_reg[c] ^ (hp_reg[c] >> 13)) * HASH_KM;
            hx[c] = hm_reg[c] ^ (hm_reg[c] >> 16);
            hf[c] = hx[c][HASH_W-1:0];
        end
        sxx = 33'((64'(tx_reg) * 64'(tx_reg)));
        syy = 33'((64'(ty_reg) * 64'(ty_reg)));
        ab = 24'((48'(h_reg[0]) * 48'(17'd65536 - sx_reg) + 48'(h_reg[1]) * 48'(sx_reg)
            + 48'd32768) >> 16);
        cd = 24'((48'(h_reg[2]) * 48'(17'd65536 - sx_reg) + 48'(h_reg[3]) * 48'(sx_reg)
            + 48'd32768) >> 16);
        nv = 24'((48'(ab_reg) * 48'(17'd65536 - sy5_reg) + 48'(cd_reg) * 48'(sy5_reg)
            + 48'd32768) >> 16);
        active = octave < s5_reg.k;
        shamt = s5_reg.k - octave - 4'd1;
        vt = (ACC_W'(nv) <<< 1) - ACC_W'(UNIT24);
    end

    function automatic logic [16:0] smooth(input logic [32:0] tt, input logic [15:0] t);
        logic [63:0] p;
        p = 64'(tt) * (64'd196608 - 64'(t) * 64'd2) + 64'h80000000;
        return 17'(p >> 32);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
            s4_reg.valid <= 1'b0;
            s5_reg.valid <= 1'b0;
            out_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            s1_reg.valid <= din.valid;
            s1_reg.x <= din.x;
            s1_reg.y <= din.y;
            s1_reg.k <= din.k;
            s1_reg.acc <= din.acc;
            s1_reg.seed <= din.seed;
            px_reg <= $signed(din.x) * $signed({1'b0, freq});
            py_reg <= $signed(din.y) * $signed({1'b0, freq});
            s2_reg <= s1_reg;
            for (int c = 0; c < 4; c++)
            begin
                hp_reg[c] <= hs[c] + salt * HASH_KS;
            end
            tx_reg <= px_reg[31:16];
            ty_reg <= py_reg[31:16];
            s3_reg <= s2_reg;
            hm_reg <= hm;
            tt_x_reg <= sxx;
            tt_y_reg <= syy;
            tx3_reg <= tx_reg;
            ty3_reg <= ty_reg;
            s4_reg <= s3_reg;
            h_reg <= hf;
            sx_reg <= smooth(tt_x_reg, tx3_reg);
            sy_reg <= smooth(tt_y_reg, ty3_reg);
            s5_reg <= s4_reg;
            ab_reg <= ab;
            cd_reg <= cd;
            sy5_reg <= sy_reg;
            out_reg.valid <= s5_reg.valid;
            out_reg.x <= s5_reg.x;
            out_reg.y <= s5_reg.y;
            out_reg.k <= s5_reg.k;
            out_reg.seed <= s5_reg.seed;
            out_reg.acc <= active ? s5_reg.acc + (vt <<< shamt) : s5_reg.acc;
        end
    end

    assign dout = out_reg;
endmodule

/* sv/vnf_norm.sv */
module vnf_norm
    import vnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  cell_bus_t   din,
    output logic        valid,
    output logic [15:0] value
);
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        neg1_reg, neg2_reg, neg3_reg;
    logic [ACC_W-1:0] mag_reg, mag2_reg, mag3_reg;
    logic [47:0] rc_reg;
    logic [31:0] den1_reg, den2_reg, den3_reg;
    logic [57:0] pl_reg, ph_reg;
    logic [16:0] q0_reg;
    logic [15:0] val_reg;
    logic [ACC_W-1:0] mag;
    logic [47:0] rc;
    logic [31:0] den;
    logic [63:0] q;
    logic [16:0] qs;
    logic [51:0] num, prod, rem;
    logic [16:0] qf;

    always_comb
    begin
        mag = din.acc[ACC_W-1] ? ACC_W'(-din.acc) : ACC_W'(din.acc);
        rc = recip(1);
        den = den_of(1);
        for (int k = 1; k <= MAX_OCTAVES; k++)
        begin
            if (din.k == OCT_W'(k))
            begin
                rc = recip(k);
                den = den_of(k);
            end
        end
        q = ((64'(ph_reg) << 24) + 64'(pl_reg) + (64'd1 << 47)) >> 48;
        qs = 17'(q);
        if (q > 64'd32768)
        begin
            qs = 17'd32768;
        end
        // step the estimate by one where the exact remainder falls outside
        num = 52'({mag3_reg, 16'd0}) + 52'(den3_reg);
        prod = (52'(q0_reg) * 52'(den3_reg)) << 1;
        rem = num - prod;
        qf = q0_reg;
        if (rem[51])
        begin
            qf = q0_reg - 17'd1;
        end
        else if (rem >= (52'(den3_reg) << 1))
        begin
            qf = q0_reg + 17'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= din.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= din.acc[ACC_W-1];
            mag_reg <= mag;
            rc_reg <= rc;
            den1_reg <= den;
            neg2_reg <= neg1_reg;
            mag2_reg <= mag_reg;
            den2_reg <= den1_reg;
            pl_reg <= 58'(64'(mag_reg) * 64'(rc_reg[23:0]));
            ph_reg <= 58'(64'(mag_reg) * 64'(rc_reg[47:24]));
            neg3_reg <= neg2_reg;
            mag3_reg <= mag2_reg;
            den3_reg <= den2_reg;
            q0_reg <= qs;
            if (neg3_reg)
            begin
                val_reg <= 16'(-$signed({1'b0, qf}));
            end
            else
            begin
                val_reg <= (qf > 17'd32767) ? 16'd32767 : qf[15:0];
            end
        end
    end

    assign valid = v4_reg;
    assign value = val_reg;
endmodule

/* sv/value_noise_fbm_2d.sv */
// Throughput: one item per cycle; each octave cell is a 6-stage pipeline.
// The chain stalls as a whole when the output register is full and not taken.
// Reset: octave_count = 4, noise_seed = 77, all pipeline valid bits cleared.
`include "value_noise_fbm_2d_macros.svh"
module value_noise_fbm_2d
    import vnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] noise_value,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [OCT_W-1:0] oct_reg;
    logic [31:0] seed_reg;
    logic [OCT_W-1:0] k_eff;
    logic en;
    logic nv;
    logic [15:0] nval;
    logic ov_reg;
    logic [15:0] oval_reg;
    cell_bus_t chain [MAX_OCTAVES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg <= OCT_W'(4);
            seed_reg <= 32'd77;
        end
        else if (cfg_we)
        begin
            unique case (int'(cfg_index))
                CFG_OCTAVE_COUNT: oct_reg <= cfg_data[OCT_W-1:0];
                CFG_NOISE_SEED:   seed_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        k_eff = oct_reg;
        if (oct_reg == '0)
        begin
            k_eff = OCT_W'(1);
        end
        else if (oct_reg > OCT_W'(MAX_OCTAVES))
        begin
            k_eff = OCT_W'(MAX_OCTAVES);
        end
        chain[0].valid = in_valid;
        chain[0].x = x_coord;
        chain[0].y = y_coord;
        chain[0].seed = seed_reg;
        chain[0].k = k_eff;
        chain[0].acc = '0;
    end

    assign en = !ov_reg || out_ready;
    assign in_ready = en;

    for (genvar g = 0; g < MAX_OCTAVES; g++)
    begin : g_cell
        vnf_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .freq(freq_q16(g)), .octave(OCT_W'(g)),
            .din(chain[g]), .dout(chain[g+1])
        );
    end

    vnf_norm u_norm (
        .clk(clk), .rst_n(rst_n), .en(en),
        .din(chain[MAX_OCTAVES]), .valid(nv), .value(nval)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= nv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oval_reg <= nval;
        end
    end

    assign out_valid = ov_reg;
    assign noise_value = oval_reg;

    `VNF_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(noise_value))
    `VNF_ASSERT_IMPL(a_ready, clk, rst_n, !out_valid, in_ready)
endmodule

/* sim/tb_value_noise_fbm_2d.sv */
module tb_value_noise_fbm_2d;
    import vnf_pkg::*;

    localparam int PIPE_LAT = 6 * MAX_OCTAVES + 4;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } point_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] noise_value;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [31:0] cfg_data;

    point_t pending_points[$];
    logic signed [15:0] expected_noise[$];

    logic [3:0] model_octaves;
    logic [31:0] model_seed;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int mismatches;
    int results_seen;
    int points_sent;
    int quiet_cycles;
    bit stim_done;
    bit in_taken;

    value_noise_fbm_2d dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .x_coord(x_coord),
        .y_coord(y_coord),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .noise_value(noise_value),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] lattice_hash(input logic [31:0] ix, input logic [31:0] iy,
                                                 input logic [31:0] seed);
        logic [31:0] h;
        h = ix * 32'd374761393 + iy * 32'd668265263 + seed * 32'd2246822519;
        h = (h ^ (h >> 13)) * 32'd1274126177;
        return (h ^ (h >> 16)) & 32'hFFFFFF;
    endfunction

    function automatic logic [63:0] smoothstep_q16(input logic [63:0] t);
        return (t * t * (64'd196608 - 64'd2 * t) + 64'h80000000) >> 32;
    endfunction

    function automatic logic [63:0] lerp_q16(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] s);
        return (a * (64'd65536 - s) + b * s + 64'd32768) >> 16;
    endfunction

    function automatic logic [63:0] octave_noise(input logic signed [63:0] px,
                                                 input logic signed [63:0] py,
                                                 input logic [31:0] seed);
        logic signed [63:0] hx;
        logic signed [63:0] hy;
        logic [31:0] ix;
        logic [31:0] iy;
        logic [63:0] sx;
        logic [63:0] sy;
        hx = px >>> 32;
        hy = py >>> 32;
        ix = hx[31:0];
        iy = hy[31:0];
        sx = smoothstep_q16({48'd0, px[31:16]});
        sy = smoothstep_q16({48'd0, py[31:16]});
        return lerp_q16(lerp_q16(lattice_hash(ix, iy, seed), lattice_hash(ix + 1, iy, seed), sx),
                        lerp_q16(lattice_hash(ix, iy + 1, seed),
                                 lattice_hash(ix + 1, iy + 1, seed), sx), sy);
    endfunction

    function automatic logic signed [15:0] fbm_noise(input point_t p);
        int k;
        logic [63:0] freq;
        logic signed [63:0] acc;
        logic signed [63:0] term;
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] q;
        k = model_octaves;
        if (k < 1) k = 1;
        if (k > MAX_OCTAVES) k = MAX_OCTAVES;
        freq = 64'd65536;
        acc = 0;
        for (int o = 0; o < k; o++)
        begin
            term = 2 * $signed(octave_noise(64'(p.x) * $signed(freq), 64'(p.y) * $signed(freq),
                                            model_seed + 32'(o) * 32'd101)) - 64'sd16777215;
            acc += term <<< (k - 1 - o);
            freq = (freq * 64'd132383 + 64'd32768) >> 16;
        end
        den = 64'd16777215 * ((64'd1 << k) - 1);
        mag = (acc < 0 ? -acc : acc) * 64'd32768;
        q = (mag * 2 + den) / (den * 2);
        if (acc < 0)
        begin
            return (q >= 32768) ? -16'sd32768 : -$signed(16'(q));
        end
        else
        begin
            return (q > 32767) ? 16'sd32767 : 16'(q);
        end
    endfunction

    task automatic write_reg(input int idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= 1'(idx);
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_OCTAVE_COUNT) model_octaves = value[3:0];
        else model_seed = value;
    endtask

    task automatic queue_point(input logic signed [31:0] x, input logic signed [31:0] y);
        point_t p;
        p.x = x;
        p.y = y;
        pending_points.push_back(p);
        points_sent++;
    endtask

    task automatic drain_pipe();
        wait (pending_points.size() == 0 && !in_valid && expected_noise.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return 32'($signed($urandom_range(0, 60000)) - 30000);
            default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            queue_point(rand_coord(), rand_coord());
        end
        drain_pipe();
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                point_t p;
                p = pending_points.pop_front();
                x_coord <= p.x;
                y_coord <= p.y;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready && rst_n;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                point_t p;
                p.x = x_coord;
                p.y = y_coord;
                expected_noise.push_back(fbm_noise(p));
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_noise.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %0d", noise_value);
                end
                else
                begin
                    logic signed [15:0] want;
                    want = expected_noise.pop_front();
                    if (want !== noise_value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("noise_value mismatch: expected %0d got %0d",
                                     want, noise_value);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || stim_done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress");
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        x_coord = '0;
        y_coord = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        model_octaves = 4'd4;
        model_seed = 32'd77;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        mismatches = 0;
        results_seen = 0;
        points_sent = 0;
        quiet_cycles = 0;
        stim_done = 0;
        in_taken = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings first, then directed corners
        queue_point(32'sh0, 32'sh0);
        queue_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        queue_point(32'sh80000000, 32'sh80000000);
        queue_point(32'sh7FFFFFFF, 32'sh80000000);
        queue_point(-32'sd1, -32'sd1);
        queue_point(32'sh00008000, 32'sh00018000);
        queue_point(32'shFFFF0000, 32'sh0000FFFF);
        queue_point(32'sh55555555, 32'shAAAAAAAA);
        drain_pipe();
        write_reg(CFG_OCTAVE_COUNT, 32'd0);
        write_reg(CFG_NOISE_SEED, 32'hFFFFFFFF);
        queue_point(32'sh12345678, -32'sd5);
        queue_point(32'sh80000000, 32'sh7FFFFFFF);
        queue_point(32'sh00010000, 32'sh00010000);
        drain_pipe();
        write_reg(CFG_OCTAVE_COUNT, 32'd15);
        write_reg(CFG_NOISE_SEED, 32'hFFFFFF00);
        queue_point(32'sh7FFFFFFF, -32'sd1);
        queue_point(32'sh80000000, 32'sh0);
        queue_point(32'sh0000C000, 32'sh00004000);
        drain_pipe();
        write_reg(CFG_OCTAVE_COUNT, 32'd8);
        write_reg(CFG_NOISE_SEED, 32'd0);
        queue_point(32'sh00123456, 32'shFFEDCBA9);
        drain_pipe();

        write_reg(CFG_OCTAVE_COUNT, 32'd1);
        write_reg(CFG_NOISE_SEED, $urandom);
        run_phase(0, 0, 100);

        write_reg(CFG_OCTAVE_COUNT, 32'd8);
        write_reg(CFG_NOISE_SEED, $urandom);
        run_phase(58, 0, 100);

        write_reg(CFG_OCTAVE_COUNT, 32'($urandom_range(2, 7)));
        write_reg(CFG_NOISE_SEED, $urandom);
        run_phase(0, 58, 100);

        write_reg(CFG_OCTAVE_COUNT, 32'($urandom_range(0, 15)));
        write_reg(CFG_NOISE_SEED, $urandom);
        send_idle_pct = 6;
        recv_stall_pct = 6;
        hold_off_cycles = 3 * PIPE_LAT;
        run_phase(6, 6, 100);

        stim_done = 1;
        $display("covered %0d points over octave counts 0..15 and four handshake mixes",
                 points_sent);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && expected_noise.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
